FILE: rtl/core/csq_pkg.sv
package csq_pkg;

  // Storage geometry
  localparam int DEPTH       = 16;
  localparam int HANDLE_BITS = 16;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int STEP_W      = $clog2(DEPTH + 1);
  localparam int OCC_W       = $clog2(DEPTH + 1);

  // Field widths on the channels
  localparam int REQ_W  = 3;
  localparam int CMD_W  = 16;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int OCC_FW = 5;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_APPEND   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PREPEND  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DELETE   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PROGRESS = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  // Slot unit operations
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_PASS   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_SHUP   = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL    = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  typedef struct packed {
    logic                   vld;
    logic [HANDLE_BITS-1:0] val;
  } slot_t;

  typedef struct packed {
    logic                   run;
    logic                   first;
    logic [OP_W-1:0]        op;
    logic [STEP_W-1:0]      step;
    logic [IDX_W-1:0]       pos;
    logic [HANDLE_BITS-1:0] handle;
  } unit_ctrl_t;

  function automatic logic [HANDLE_BITS-1:0] to_slot(input logic [CMD_W-1:0] h);
    logic [HANDLE_BITS-1:0] r;
    r = '0;
    for (int b = 0; b < HANDLE_BITS; b++) begin
      if (b < CMD_W) r[b] = h[b];
    end
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] from_slot(input logic [HANDLE_BITS-1:0] h);
    logic [CMD_W-1:0] r;
    r = '0;
    for (int b = 0; b < CMD_W; b++) begin
      if (b < HANDLE_BITS) r[b] = h[b];
    end
    return r;
  endfunction

  function automatic logic [OCC_FW-1:0] occ_field(input logic [OCC_W-1:0] c);
    logic [OCC_FW-1:0] r;
    r = '0;
    for (int b = 0; b < OCC_FW; b++) begin
      if (b < OCC_W) r[b] = c[b];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/csq_if.sv
interface csq_req_if;
  logic                      valid;
  logic                      ready;
  logic [csq_pkg::REQ_W-1:0] req_type;
  logic [csq_pkg::CMD_W-1:0] cmd_handle;
  logic [csq_pkg::POS_W-1:0] position;
  logic                      head_done;

  modport source (output valid, req_type, cmd_handle, position, head_done, input ready);
  modport sink   (input valid, req_type, cmd_handle, position, head_done, output ready);
endinterface

interface csq_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [csq_pkg::STAT_W-1:0] status;
  logic                       head_valid;
  logic [csq_pkg::CMD_W-1:0]  head_value;
  logic [csq_pkg::OCC_FW-1:0] occupancy;

  modport source (output valid, status, head_valid, head_value, occupancy, input ready);
  modport sink   (input valid, status, head_valid, head_value, occupancy, output ready);
endinterface

FILE: rtl/core/command_slot_queue.sv
// Command slot queue: one request in, one result out.
// Each request is one pass of the ring past the single slot unit at its tap, one ring step
// per cycle; delete-first and completed progress take an extra step. The result waits in
// a result state, and no new request is taken until that result has been taken.
// Reset (rst_ni low, async): all slots empty, sequencer idle, no result pending.
module command_slot_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  csq_req_if.sink          req_i,
  csq_rsp_if.source        rsp_o
);

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_RESP = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [csq_pkg::STEP_W-1:0]      step_q, step_d, last_step_q, last_step_d;
  logic [csq_pkg::OP_W-1:0]        op_q, op_d;
  logic [csq_pkg::STAT_W-1:0]      status_q, status_d;
  logic [csq_pkg::IDX_W-1:0]       pos_q, pos_d;
  logic [csq_pkg::HANDLE_BITS-1:0] handle_q, handle_d;

  csq_pkg::slot_t      tap, last, tail;
  csq_pkg::unit_ctrl_t ctrl;
  logic [csq_pkg::OCC_W-1:0] occ;
  logic placed;
  logic accept, running;

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign running     = (state_q == S_RUN);

  // Decode the request into a ring pass. Refusals are a plain pass so the
  // occupancy count still comes out of the walk.
  always_comb begin
    op_d        = op_q;
    status_d    = status_q;
    pos_d       = pos_q;
    handle_d    = handle_q;
    last_step_d = last_step_q;
    if (accept) begin
      op_d        = csq_pkg::OP_PASS;
      status_d    = csq_pkg::ST_OK;
      pos_d       = '0;
      handle_d    = csq_pkg::to_slot(req_i.cmd_handle);
      last_step_d = csq_pkg::STEP_W'(csq_pkg::DEPTH - 1);
      case (req_i.req_type)
        csq_pkg::REQ_APPEND: op_d = csq_pkg::OP_APPEND;
        csq_pkg::REQ_PREPEND: begin
          if (last.vld) status_d = csq_pkg::ST_FULL;
          else          op_d     = csq_pkg::OP_SHUP;
        end
        csq_pkg::REQ_INSERT: begin
          // position range is checked ahead of the full check
          if (32'(req_i.position) >= csq_pkg::DEPTH) begin
            status_d = csq_pkg::ST_BADPOS;
          end else if (last.vld) begin
            status_d = csq_pkg::ST_FULL;
          end else begin
            op_d  = csq_pkg::OP_SHUP;
            pos_d = csq_pkg::IDX_W'(req_i.position);
          end
        end
        csq_pkg::REQ_DELETE: begin
          op_d        = csq_pkg::OP_DEL;
          last_step_d = csq_pkg::STEP_W'(csq_pkg::DEPTH);
          if (!tap.vld) status_d = csq_pkg::ST_EMPTY;
        end
        csq_pkg::REQ_CLEAR: op_d = csq_pkg::OP_CLEAR;
        csq_pkg::REQ_PROGRESS: begin
          if (tap.vld && req_i.head_done) begin
            op_d        = csq_pkg::OP_DEL;
            last_step_d = csq_pkg::STEP_W'(csq_pkg::DEPTH);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_RUN;
          step_d  = '0;
        end
      end
      S_RUN: begin
        step_d = step_q + 1'b1;
        if (step_q == last_step_q) state_d = S_RESP;
      end
      S_RESP: begin
        if (rsp_o.ready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Request payload, held for the pass
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    status_q    <= status_d;
    pos_q       <= pos_d;
    handle_q    <= handle_d;
    last_step_q <= last_step_d;
  end

  assign ctrl.run    = running;
  assign ctrl.first  = (step_q == '0);
  assign ctrl.op     = op_q;
  assign ctrl.step   = step_q;
  assign ctrl.pos    = pos_q;
  assign ctrl.handle = handle_q;

  csq_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (running),
    .tail_i  (tail),
    .tap_o   (tap),
    .last_o  (last)
  );

  csq_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .elem_i   (tap),
    .elem_o   (tail),
    .occ_o    (occ),
    .placed_o (placed)
  );

  // Result: ring is back in place and holds still while the item waits.
  assign rsp_o.valid      = (state_q == S_RESP);
  assign rsp_o.status     = (op_q == csq_pkg::OP_APPEND && !placed) ? csq_pkg::ST_FULL
                                                                     : status_q;
  assign rsp_o.head_valid = tap.vld;
  assign rsp_o.head_value = tap.vld ? csq_pkg::from_slot(tap.val) : '0;
  assign rsp_o.occupancy  = csq_pkg::occ_field(occ);

endmodule

FILE: rtl/core/csq_ring.sv
// Slot ring: rotates one place toward the head per shift; tail takes the unit output.
module csq_ring (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  csq_pkg::slot_t tail_i,
  output csq_pkg::slot_t tap_o,
  output csq_pkg::slot_t last_o
);

  logic [csq_pkg::HANDLE_BITS-1:0] val_q [csq_pkg::DEPTH];
  logic [csq_pkg::DEPTH-1:0]       vld_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      for (int k = 0; k < csq_pkg::DEPTH - 1; k++) begin
        val_q[k] <= val_q[k+1];
      end
      val_q[csq_pkg::DEPTH-1] <= tail_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (shift_i) begin
      vld_q <= {tail_i.vld, vld_q[csq_pkg::DEPTH-1:1]};
    end
  end

  assign tap_o.vld  = vld_q[0];
  assign tap_o.val  = val_q[0];
  assign last_o.vld = vld_q[csq_pkg::DEPTH-1];
  assign last_o.val = val_q[csq_pkg::DEPTH-1];

endmodule

FILE: rtl/core/csq_unit.sv
// Slot unit: rewrites the slot at the ring tap and counts occupied slots.
module csq_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  csq_pkg::unit_ctrl_t        ctrl_i,
  input  csq_pkg::slot_t             elem_i,
  output csq_pkg::slot_t             elem_o,
  output logic [csq_pkg::OCC_W-1:0]  occ_o,
  output logic                       placed_o
);

  csq_pkg::slot_t                carry_q, carry_d;
  logic                          placed_q, placed_d, placed_eff;
  logic [csq_pkg::OCC_W-1:0]     occ_q, occ_d, occ_base;
  logic [csq_pkg::STEP_W-1:0]    pos_step;
  logic                          counted;

  assign placed_eff = ctrl_i.first ? 1'b0 : placed_q;
  assign occ_base   = ctrl_i.first ? '0 : occ_q;
  assign pos_step   = csq_pkg::STEP_W'(ctrl_i.pos);
  assign counted    = ctrl_i.step < csq_pkg::STEP_W'(csq_pkg::DEPTH);

  always_comb begin
    elem_o   = elem_i;
    carry_d  = carry_q;
    placed_d = placed_eff;
    case (ctrl_i.op)
      csq_pkg::OP_APPEND: begin
        if (!elem_i.vld && !placed_eff) begin
          elem_o.vld = 1'b1;
          elem_o.val = ctrl_i.handle;
          placed_d   = 1'b1;
        end
      end
      csq_pkg::OP_SHUP: begin
        if (ctrl_i.step == pos_step) begin
          elem_o.vld = 1'b1;
          elem_o.val = ctrl_i.handle;
          carry_d    = elem_i;
        end else if (ctrl_i.step > pos_step) begin
          elem_o  = carry_q;
          carry_d = elem_i;
        end
      end
      csq_pkg::OP_DEL: begin
        // Head leaves at step zero; the extra step completes the shift.
        if (ctrl_i.step == '0) elem_o.vld = 1'b0;
      end
      csq_pkg::OP_CLEAR: elem_o.vld = 1'b0;
      default: ;
    endcase
    occ_d = occ_base + csq_pkg::OCC_W'(elem_o.vld && counted);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.run) carry_q <= carry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      placed_q <= 1'b0;
      occ_q    <= '0;
    end else if (ctrl_i.run) begin
      placed_q <= placed_d;
      occ_q    <= occ_d;
    end
  end

  assign occ_o    = occ_q;
  assign placed_o = placed_q;

endmodule

FILE: rtl/core/csq_chk.sv
module csq_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [csq_pkg::STAT_W-1:0] status_i,
  input logic                       head_valid_i,
  input logic [csq_pkg::CMD_W-1:0]  head_value_i,
  input logic [csq_pkg::OCC_FW-1:0] occupancy_i
);

  // One request at a time: no new request while a result is offered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !req_ready_i)
    else $error("request taken while result pending");

  // A result never comes in the cycle right after a request is taken.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !rsp_valid_i)
    else $error("result too early");

  // Empty head reads as zero and an occupied head implies nonzero occupancy.
  a_head_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (head_valid_i ? (occupancy_i != '0) : (head_value_i == '0)))
    else $error("head and occupancy disagree");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(head_value_i) && $stable(occupancy_i))
    else $error("stalled result changed");

endmodule

bind command_slot_queue csq_chk u_csq_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .head_valid_i (rsp_o.head_valid),
  .head_value_i (rsp_o.head_value),
  .occupancy_i  (rsp_o.occupancy)
);

FILE: test/csq_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow copy of the slot row and checks each
// reply against the one predicted for the oldest outstanding request.
module csq_checker
  import csq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  csq_req_if   req_mon,
  csq_rsp_if   rsp_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              head_valid;
    logic [CMD_W-1:0]  head_value;
    logic [OCC_FW-1:0] occupancy;
  } reply_t;

  logic [HANDLE_BITS-1:0] shadow_handle [DEPTH];
  bit                     shadow_used   [DEPTH];
  reply_t                 awaited_replies [$];

  // slots [from, DEPTH-2] move up one; slot "from" keeps its content
  function automatic void open_gap_at(int from);
    int i;
    for (i = DEPTH - 1; i > from; i--) begin
      shadow_handle[i] = shadow_handle[i-1];
      shadow_used[i]   = shadow_used[i-1];
    end
  endfunction

  function automatic void pop_head();
    int i;
    for (i = 0; i < DEPTH - 1; i++) begin
      shadow_handle[i] = shadow_handle[i+1];
      shadow_used[i]   = shadow_used[i+1];
    end
    shadow_used[DEPTH-1] = 1'b0;
  endfunction

  function automatic reply_t apply_request(input logic [REQ_W-1:0] kind,
                                           input logic [CMD_W-1:0] handle,
                                           input logic [POS_W-1:0] pos,
                                           input logic             done);
    reply_t                 r;
    logic [HANDLE_BITS-1:0] h;
    int                     i;
    int                     count;
    bit                     placed;
    r      = '0;
    h      = HANDLE_BITS'(handle);
    count  = 0;
    placed = 1'b0;
    r.status = ST_OK;
    case (kind)
      REQ_APPEND: begin
        for (i = 0; i < DEPTH; i++) begin
          if (!placed && !shadow_used[i]) begin
            shadow_handle[i] = h;
            shadow_used[i]   = 1'b1;
            placed           = 1'b1;
          end
        end
        if (!placed) r.status = ST_FULL;
      end
      REQ_PREPEND: begin
        if (shadow_used[DEPTH-1]) begin
          r.status = ST_FULL;
        end else begin
          open_gap_at(0);
          shadow_handle[0] = h;
          shadow_used[0]   = 1'b1;
        end
      end
      REQ_INSERT: begin
        // position is checked before fullness
        if (int'(pos) >= DEPTH) begin
          r.status = ST_BADPOS;
        end else if (shadow_used[DEPTH-1]) begin
          r.status = ST_FULL;
        end else begin
          open_gap_at(int'(pos));
          shadow_handle[pos] = h;
          shadow_used[pos]   = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (!shadow_used[0]) r.status = ST_EMPTY;
        pop_head();
      end
      REQ_CLEAR: begin
        for (i = 0; i < DEPTH; i++) shadow_used[i] = 1'b0;
      end
      REQ_PROGRESS: begin
        if (shadow_used[0] && done) pop_head();
      end
      default: begin
      end
    endcase
    for (i = 0; i < DEPTH; i++) begin
      if (shadow_used[i]) count++;
    end
    r.head_valid = shadow_used[0];
    r.head_value = shadow_used[0] ? CMD_W'(shadow_handle[0]) : '0;
    r.occupancy  = OCC_FW'(count);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t want;
    int     i;
    if (!rst_ni) begin
      awaited_replies.delete();
      for (i = 0; i < DEPTH; i++) begin
        shadow_used[i]   = 1'b0;
        shadow_handle[i] = '0;
      end
      fail_count_o = 0;
    end else begin
      // a reply never belongs to a request accepted on the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_replies.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: reply with nothing outstanding: st=%0d hv=%0b val=%h occ=%0d",
                     $time, rsp_mon.status, rsp_mon.head_valid, rsp_mon.head_value,
                     rsp_mon.occupancy);
        end else begin
          want = awaited_replies.pop_front();
          if (want.status     !== rsp_mon.status     ||
              want.head_valid !== rsp_mon.head_valid ||
              want.head_value !== rsp_mon.head_value ||
              want.occupancy  !== rsp_mon.occupancy) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch exp st=%0d hv=%0b val=%h occ=%0d got st=%0d hv=%0b val=%h occ=%0d",
                       $time, want.status, want.head_valid, want.head_value, want.occupancy,
                       rsp_mon.status, rsp_mon.head_valid, rsp_mon.head_value,
                       rsp_mon.occupancy);
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        awaited_replies.push_back(apply_request(req_mon.req_type, req_mon.cmd_handle,
                                                req_mon.position, req_mon.head_done));
    end
    pending_o = awaited_replies.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the command slot queue. Prediction and comparison
// live in csq_checker, which sits on the same two channels.
module tb_top;
  import csq_pkg::*;

  // Kinds the block must ignore
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_WAIT   = 40;      // about two passes of the block
  localparam int CYCLE_LIMIT  = 600000;
  localparam int LONG_HOLD    = 300;     // receiver hold-off, in cycles

  logic clk_i = 1'b0;
  logic rst_ni;

  int mismatches;
  int in_flight;
  int burst_left = 0;

  csq_req_if req_bus ();
  csq_rsp_if rsp_bus ();

  command_slot_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  csq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_bus),
    .rsp_mon      (rsp_bus),
    .fail_count_o (mismatches),
    .pending_o    (in_flight)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offer one item and hold it until the block takes it. Items go out in
  // bursts; between bursts valid drops for a random gap (sometimes none).
  task automatic issue(input logic [REQ_W-1:0] kind, input logic [CMD_W-1:0] handle,
                       input logic [POS_W-1:0] pos, input logic done);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= kind;
    req_bus.cmd_handle <= handle;
    req_bus.position   <= pos;
    req_bus.head_done  <= done;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  // One random request. While growing, most requests add entries so the row
  // fills up and the full cases get hit; while shrinking, deletes and
  // completed progress dominate so the row runs empty again.
  task automatic random_request(input bit growing, output bit counted);
    int               r;
    logic [REQ_W-1:0] kind;
    logic [CMD_W-1:0] h;
    logic [POS_W-1:0] p;
    logic             d;
    r = $urandom_range(0, 99);
    h = CMD_W'($urandom_range(0, 65535));
    if ($urandom_range(0, 15) == 0) h = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    p = POS_W'($urandom_range(0, DEPTH - 1));
    d = growing ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) != 0);
    if (growing) begin
      if      (r < 45) kind = REQ_APPEND;
      else if (r < 60) kind = REQ_PREPEND;
      else if (r < 80) kind = REQ_INSERT;
      else if (r < 88) kind = REQ_DELETE;
      else if (r < 94) kind = REQ_PROGRESS;
      else if (r < 95) kind = REQ_CLEAR;
      else if (r < 97) kind = ($urandom_range(0, 1) == 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
      else begin
        kind = REQ_INSERT;
        p    = POS_W'($urandom_range(DEPTH, 31));
      end
    end else begin
      if      (r < 10) kind = REQ_APPEND;
      else if (r < 15) kind = REQ_PREPEND;
      else if (r < 22) kind = REQ_INSERT;
      else if (r < 55) kind = REQ_DELETE;
      else if (r < 90) kind = REQ_PROGRESS;
      else if (r < 93) kind = REQ_CLEAR;
      else if (r < 96) kind = ($urandom_range(0, 1) == 1) ? REQ_SPARE_HI : REQ_SPARE_LO;
      else begin
        kind = REQ_INSERT;
        p    = POS_W'($urandom_range(DEPTH, 31));
      end
    end
    counted = (kind != REQ_SPARE_LO) && (kind != REQ_SPARE_HI);
    issue(kind, h, p, d);
  endtask

  // Receiver: stretches of always-ready, a rotating stall pattern, or sparse
  // ready. Twice it holds off for a long stretch while the sender keeps
  // offering, so the block backs up and stalls its input.
  initial begin
    int         rx_cycles;
    int         holds_done;
    int         mode;
    int         stretch;
    int         k;
    logic [7:0] pat;
    rx_cycles  = 0;
    holds_done = 0;
    rsp_bus.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if ((holds_done == 0 && rx_cycles >= 3000) ||
          (holds_done == 1 && rx_cycles >= 16000)) begin
        rsp_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_cycles += LONG_HOLD;
        holds_done++;
      end else begin
        mode    = $urandom_range(0, 2);
        stretch = $urandom_range(20, 200);
        pat     = 8'($urandom_range(1, 255));
        for (k = 0; k < stretch; k++) begin
          case (mode)
            0:       rsp_bus.ready <= 1'b1;
            1:       rsp_bus.ready <= pat[k % 8];
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
          rx_cycles++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** command_slot_queue: FAILED **");
    $finish;
  end

  initial begin
    int  n_random;
    int  n_issued;
    int  phase_left;
    bit  growing;
    bit  counted;
    rst_ni             <= 1'b0;
    req_bus.valid      <= 1'b0;
    req_bus.req_type   <= REQ_APPEND;
    req_bus.cmd_handle <= '0;
    req_bus.position   <= '0;
    req_bus.head_done  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    issue(REQ_DELETE,   16'h0000, 5'd0,  1'b0);  // delete with empty head
    issue(REQ_PROGRESS, 16'h0000, 5'd0,  1'b1);  // progress, head empty
    issue(REQ_APPEND,   16'h0000, 5'd0,  1'b0);  // smallest handle
    issue(REQ_APPEND,   16'hFFFF, 5'd31, 1'b1);  // largest handle
    issue(REQ_PREPEND,  16'h1234, 5'd0,  1'b0);
    issue(REQ_PROGRESS, 16'h0000, 5'd0,  1'b0);  // head not done: no change
    issue(REQ_PROGRESS, 16'h0000, 5'd0,  1'b1);  // head done: pops
    issue(REQ_INSERT,   16'hABCD, 5'd1,  1'b0);
    issue(REQ_INSERT,   16'h2222, 5'd16, 1'b0);  // first bad position
    issue(REQ_INSERT,   16'h3333, 5'd31, 1'b1);  // last bad position
    issue(REQ_INSERT,   16'h4444, 5'd10, 1'b0);  // past the entries: leaves gaps
    issue(REQ_SPARE_LO, 16'h5A5A, 5'd3,  1'b1);  // unknown kinds are ignored
    issue(REQ_SPARE_HI, 16'hA5A5, 5'd21, 1'b0);
    issue(REQ_DELETE,   16'h0000, 5'd0,  1'b0);  // head valid
    issue(REQ_INSERT,   16'h5555, 5'd15, 1'b0);  // occupies last slot
    issue(REQ_PREPEND,  16'h6666, 5'd0,  1'b0);  // last slot taken: dropped
    issue(REQ_INSERT,   16'h7777, 5'd0,  1'b0);  // same
    issue(REQ_INSERT,   16'h8888, 5'd20, 1'b0);  // bad position wins over full
    issue(REQ_APPEND,   16'h9999, 5'd0,  1'b0);  // fills a gap
    issue(REQ_CLEAR,    16'h0000, 5'd0,  1'b0);
    issue(REQ_INSERT,   16'hBEEF, 5'd0,  1'b0);  // insert into empty row
    issue(REQ_PROGRESS, 16'h0000, 5'd0,  1'b1);
    issue(REQ_CLEAR,    16'h0000, 5'd0,  1'b0);

    // --- random part ---
    n_random   = 0;
    n_issued   = 0;
    phase_left = 0;
    growing    = 1'b1;
    while (n_random < RANDOM_ITEMS) begin
      if (phase_left == 0) begin
        growing    = ~growing;
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      random_request(growing, counted);
      if (counted) n_random++;
      n_issued++;
      // once, let everything outstanding come back before going on
      if (n_issued == 500) begin
        req_bus.valid <= 1'b0;
        do @(posedge clk_i); while (in_flight != 0);
        burst_left = 0;
      end
    end
    req_bus.valid <= 1'b0;

    do @(posedge clk_i); while (in_flight != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && in_flight == 0) begin
      $display("** command_slot_queue: PASSED **");
    end else begin
      $display("** command_slot_queue: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/csq_pkg.sv
rtl/core/csq_if.sv
rtl/core/csq_ring.sv
rtl/core/csq_unit.sv
rtl/core/command_slot_queue.sv
rtl/core/csq_chk.sv
test/csq_checker.sv
test/tb_top.sv
